// ===== hdl/periodic_timer_table_macros.svh =====
// Assertion macros used by the timer table engine.
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH
// Checked on every clock edge except while reset is high.
`define PTT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define PTT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/ptt_pkg.sv =====
// Types, codes and constants of the periodic timer table.
package ptt_pkg;
   localparam int SLOTS  = 16;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] FUNC_SET  = 2'd0;
   localparam logic [1:0] FUNC_KILL = 2'd1;
   localparam logic [1:0] FUNC_KALL = 2'd2;
   localparam logic [1:0] FUNC_TICK = 2'd3;

   localparam logic [2:0] KIND_SET_OK   = 3'd0;
   localparam logic [2:0] KIND_REP_ZERO = 3'd1;
   localparam logic [2:0] KIND_FULL     = 3'd2;
   localparam logic [2:0] KIND_KILLED   = 3'd3;
   localparam logic [2:0] KIND_NOTFOUND = 3'd4;
   localparam logic [2:0] KIND_ALL_KILL = 3'd5;
   localparam logic [2:0] KIND_FIRE     = 3'd6;
   localparam logic [2:0] KIND_TICKDONE = 3'd7;

   localparam logic [1:0] ADDR_TICK = 2'd0;

   localparam logic [19:0] TICK_RESET = 20'd50000;
   localparam logic [63:0] NONE_DUE   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] FOREVER    = 32'hFFFF_FFFF;

   // Microseconds to whole milliseconds: (x * MS_RECIP) >> MS_SHIFT equals x / 1000
   // for every 20-bit x.
   localparam logic [20:0] MS_RECIP = 21'd1073742;
   localparam int          MS_SHIFT = 30;

   localparam int DVD_W = 26;
   localparam int DVS_W = 11;
   localparam int CNT_W = $clog2(DVD_W);

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] timer_id;
      logic [15:0] period_s;
      logic [31:0] repeat_count;
      logic [31:0] user_param;
      logic [63:0] now_us;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [31:0] fired_id;
      logic [31:0] fired_param;
      logic        last;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    rep_zero;
   } cmd_type;
endpackage

// ===== hdl/ptt_cmd_queue.sv =====
// Front end: accepts commands, flags rejected sets and queues them.
module ptt_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ptt_pkg::req_type  req_data,
   output logic              cmd_valid,
   output ptt_pkg::cmd_type  cmd_data,
   input  logic              cmd_take
);
   ptt_pkg::cmd_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;
   ptt_pkg::cmd_type entry;

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = mem_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      entry.req      = req_data;
      entry.rep_zero = (req_data.func == ptt_pkg::FUNC_SET) && (req_data.repeat_count == 32'd0);
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= entry;
      end
   end
endmodule

// ===== hdl/ptt_rsp_queue.sv =====
// Result queue: parts the engine from the consumer of results.
module ptt_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_push,
   output logic              in_full,
   input  ptt_pkg::rsp_type  in_data,
   output logic              empty,
   input  logic              pop,
   output ptt_pkg::rsp_type  rsp_data
);
   ptt_pkg::rsp_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign in_full  = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign rsp_data = mem_ff[rd_ff];
   assign do_push  = in_push && !in_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end
endmodule

// ===== hdl/ptt_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module ptt_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ptt_pkg::DVD_W-1:0]   dividend,
   input  logic [ptt_pkg::DVS_W-1:0]   divisor,
   output logic                        done,
   output logic [ptt_pkg::DVS_W-1:0]   rem
);
   logic                        busy_ff, busy_in, done_ff, done_in;
   logic [ptt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ptt_pkg::DVD_W-1:0]   quo_ff, quo_in;
   logic [ptt_pkg::DVS_W-1:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [ptt_pkg::DVS_W:0]     trial;
   logic                        qbit;

   assign done = done_ff;
   assign rem  = rem_ff;

   always_comb begin
      trial   = {rem_ff, quo_ff[ptt_pkg::DVD_W-1]};
      qbit    = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ptt_pkg::CNT_W'(ptt_pkg::DVD_W - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? ptt_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                       : ptt_pkg::DVS_W'(trial);
         quo_in = {quo_ff[ptt_pkg::DVD_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end
endmodule

// ===== hdl/ptt_engine.sv =====
// Back end: slot table and the sequencer that carries out each command.
`include "periodic_timer_table_macros.svh"
module ptt_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  ptt_pkg::cmd_type  cmd_data,
   output logic              cmd_take,
   input  logic [19:0]       tick_period_us,
   input  logic              rsp_full,
   output logic              rsp_push,
   output ptt_pkg::rsp_type  rsp_out
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_DIV1  = 4'd2;
   localparam logic [3:0] S_DIV2  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_ADD   = 4'd5;
   localparam logic [3:0] S_EMIT  = 4'd6;
   localparam logic [3:0] S_TSLOT = 4'd7;
   localparam logic [3:0] S_TMIN  = 4'd8;
   localparam logic [ptt_pkg::SLOT_W-1:0] LAST_IDX = ptt_pkg::SLOT_W'(ptt_pkg::SLOTS - 1);

   logic [31:0] slot_id_ff   [ptt_pkg::SLOTS];
   logic [39:0] slot_per_ff  [ptt_pkg::SLOTS];
   logic [63:0] slot_dl_ff   [ptt_pkg::SLOTS];
   logic [31:0] slot_rep_ff  [ptt_pkg::SLOTS];
   logic [31:0] slot_par_ff  [ptt_pkg::SLOTS];
   logic [ptt_pkg::SLOTS-1:0] valid_ff, valid_in;

   logic [3:0]  state_ff, state_in;
   ptt_pkg::req_type cmd_ff, cmd_in;
   logic [ptt_pkg::SLOT_W-1:0] idx_ff, idx_in, hit_ff, hit_in, free_ff, free_in;
   logic        found_ff, found_in, freef_ff, freef_in;
   logic [63:0] ed_ff, ed_in, next_ff, next_in;
   logic [2:0]  kind_ff, kind_in;
   logic [31:0] eid_ff, eid_in;
   logic [ptt_pkg::DVS_W-1:0] tms_ff, tms_in;
   logic [ptt_pkg::DVD_W-1:0] x_ff, x_in, ms_ff, ms_in;
   logic [39:0] per_ff, per_in;

   logic        wr_slot, wr_tick;
   logic [ptt_pkg::SLOT_W-1:0] tgt;
   logic [63:0] dl_new, dl_adv;
   logic [31:0] rep_dec;
   logic [40:0] tick_prod;
   logic        kall_take, table_clear;

   logic        div_start, div_done;
   logic [ptt_pkg::DVD_W-1:0] div_dvd;
   logic [ptt_pkg::DVS_W-1:0] div_dvs, div_r, tms_c;

   ptt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .rem      (div_r)
   );

   assign tgt    = found_ff ? hit_ff : free_ff;
   assign dl_new = cmd_ff.now_us + 64'(per_ff);
   assign dl_adv = slot_dl_ff[idx_ff] + 64'(slot_per_ff[idx_ff]);
   assign rep_dec = slot_rep_ff[idx_ff] - 32'd1;
   // Tick length in whole milliseconds by reciprocal multiplication; a zero becomes 1 ms.
   assign tick_prod = 41'(tick_period_us) * 41'(ptt_pkg::MS_RECIP);
   assign tms_c  = (tick_prod[ptt_pkg::MS_SHIFT +: ptt_pkg::DVS_W] == '0)
                   ? ptt_pkg::DVS_W'(1) : tick_prod[ptt_pkg::MS_SHIFT +: ptt_pkg::DVS_W];
   assign kall_take   = cmd_take && cmd_data.req.func == ptt_pkg::FUNC_KALL;
   assign table_clear = (valid_ff == '0) && (ed_ff == ptt_pkg::NONE_DUE);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      hit_in    = hit_ff;
      free_in   = free_ff;
      found_in  = found_ff;
      freef_in  = freef_ff;
      ed_in     = ed_ff;
      next_in   = next_ff;
      kind_in   = kind_ff;
      eid_in    = eid_ff;
      tms_in    = tms_ff;
      x_in      = x_ff;
      ms_in     = ms_ff;
      per_in    = per_ff;
      valid_in  = valid_ff;
      cmd_take  = 1'b0;
      rsp_push  = 1'b0;
      rsp_out   = '0;
      wr_slot   = 1'b0;
      wr_tick   = 1'b0;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in   = cmd_data.req;
               idx_in   = '0;
               found_in = 1'b0;
               freef_in = 1'b0;
               eid_in   = cmd_data.req.timer_id;
               case (cmd_data.req.func)
                  ptt_pkg::FUNC_SET: begin
                     if (cmd_data.rep_zero) begin
                        kind_in  = ptt_pkg::KIND_REP_ZERO;
                        state_in = S_EMIT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ptt_pkg::FUNC_KILL: state_in = S_SCAN;
                  ptt_pkg::FUNC_KALL: begin
                     valid_in = '0;
                     ed_in    = ptt_pkg::NONE_DUE;
                     kind_in  = ptt_pkg::KIND_ALL_KILL;
                     eid_in   = '0;
                     state_in = S_EMIT;
                  end
                  default: begin
                     eid_in  = '0;
                     kind_in = ptt_pkg::KIND_TICKDONE;
                     next_in = ptt_pkg::NONE_DUE;
                     if (ed_ff != ptt_pkg::NONE_DUE && ed_ff <= cmd_data.req.now_us) begin
                        state_in = S_TSLOT;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (valid_ff[idx_ff] && slot_id_ff[idx_ff] == cmd_ff.timer_id && !found_ff) begin
               found_in = 1'b1;
               hit_in   = idx_ff;
            end
            if (!valid_ff[idx_ff] && !freef_ff) begin
               freef_in = 1'b1;
               free_in  = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               // Results of the walk are held in registers and read again in S_ADD.
               state_in = S_DIV1;
               idx_in   = '0;
               if (cmd_ff.func == ptt_pkg::FUNC_KILL) begin
                  state_in = S_EMIT;
                  kind_in  = ptt_pkg::KIND_NOTFOUND;
               end
            end
            if (idx_ff == LAST_IDX && cmd_ff.func == ptt_pkg::FUNC_KILL &&
                (found_ff || (valid_ff[idx_ff] && slot_id_ff[idx_ff] == cmd_ff.timer_id))) begin
               kind_in = ptt_pkg::KIND_KILLED;
               valid_in[found_ff ? hit_ff : idx_ff] = 1'b0;
               if ((valid_ff & ~(ptt_pkg::SLOTS'(1) << (found_ff ? hit_ff : idx_ff))) == '0) begin
                  ed_in = ptt_pkg::NONE_DUE;
               end
            end
            if (idx_ff == LAST_IDX && cmd_ff.func == ptt_pkg::FUNC_SET) begin
               if (found_in || freef_in) begin
                  tms_in = tms_c;
                  x_in   = ptt_pkg::DVD_W'(cmd_ff.period_s) * ptt_pkg::DVD_W'(1000);
               end else begin
                  kind_in  = ptt_pkg::KIND_FULL;
                  state_in = S_EMIT;
               end
            end
         end
         S_DIV1: begin
            div_start = 1'b1;
            div_dvd   = x_ff;
            div_dvs   = tms_ff;
            state_in  = S_DIV2;
         end
         S_DIV2: begin
            if (div_done) begin
               ms_in = x_ff + ((div_r == '0) ? '0 : ptt_pkg::DVD_W'(tms_ff - div_r));
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            per_in   = 40'(ms_ff) * 40'd1000;
            state_in = S_ADD;
         end
         S_ADD: begin
            wr_slot       = 1'b1;
            valid_in[tgt] = 1'b1;
            if (dl_new < ed_ff) begin
               ed_in = dl_new;
            end
            kind_in  = ptt_pkg::KIND_SET_OK;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push            = 1'b1;
               rsp_out.result_kind = kind_ff;
               rsp_out.fired_id    = eid_ff;
               rsp_out.last        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         S_TSLOT: begin
            if (valid_ff[idx_ff] && slot_dl_ff[idx_ff] <= cmd_ff.now_us) begin
               if (!rsp_full) begin
                  rsp_push            = 1'b1;
                  rsp_out.result_kind = ptt_pkg::KIND_FIRE;
                  rsp_out.fired_id    = slot_id_ff[idx_ff];
                  rsp_out.fired_param = slot_par_ff[idx_ff];
                  if (slot_rep_ff[idx_ff] != ptt_pkg::FOREVER &&
                      slot_rep_ff[idx_ff] <= 32'd1) begin
                     // Count ran out: release the slot, it takes no part in the minimum.
                     valid_in[idx_ff] = 1'b0;
                     idx_in = idx_ff + 1'b1;
                     if (idx_ff == LAST_IDX) begin
                        ed_in    = next_ff;
                        state_in = S_EMIT;
                     end
                  end else begin
                     wr_tick  = 1'b1;
                     state_in = S_TMIN;
                  end
               end
            end else if (valid_ff[idx_ff]) begin
               state_in = S_TMIN;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST_IDX) begin
                  ed_in    = next_ff;
                  state_in = S_EMIT;
               end
            end
         end
         S_TMIN: begin
            if (slot_dl_ff[idx_ff] < next_ff) begin
               next_in = slot_dl_ff[idx_ff];
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_TSLOT;
            if (idx_ff == LAST_IDX) begin
               ed_in    = next_in;
               state_in = S_EMIT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         ed_ff    <= ptt_pkg::NONE_DUE;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ed_ff    <= ed_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      hit_ff   <= hit_in;
      free_ff  <= free_in;
      found_ff <= found_in;
      freef_ff <= freef_in;
      next_ff  <= next_in;
      kind_ff  <= kind_in;
      eid_ff   <= eid_in;
      tms_ff   <= tms_in;
      x_ff     <= x_in;
      ms_ff    <= ms_in;
      per_ff   <= per_in;
   end

   always_ff @(posedge clock) begin
      if (wr_slot) begin
         slot_id_ff[tgt]  <= cmd_ff.timer_id;
         slot_per_ff[tgt] <= per_ff;
         slot_dl_ff[tgt]  <= dl_new;
         slot_rep_ff[tgt] <= cmd_ff.repeat_count;
         slot_par_ff[tgt] <= cmd_ff.user_param;
      end
      if (wr_tick) begin
         slot_dl_ff[idx_ff] <= dl_adv;
         if (slot_rep_ff[idx_ff] != ptt_pkg::FOREVER) begin
            slot_rep_ff[idx_ff] <= rep_dec;
         end
      end
   end

   `PTT_ASSERT(a_push_room, clock, reset, rsp_push |-> !rsp_full, "result pushed into a full queue")
   `PTT_ASSERT(a_take_idle, clock, reset, cmd_take |-> state_ff == S_IDLE, "command taken while busy")
   `PTT_ASSERT(a_kall_none, clock, reset, kall_take |=> table_clear, "kill all left state behind")
endmodule

// ===== hdl/periodic_timer_table.sv =====
// Top level of the periodic timer table: queues, engine and register port.
//
//   channel   direction  accepted when
//   command   in         push && !full
//   result    out        pop && !empty
//   csr       in         psel && penable && pwrite (pready tied high)
//
// Engine work per command: kill all, a set with a zero repeat count and a tick with nothing
// due skip the slot walk; kill and a set into a full table walk every slot; a set that arms
// a slot walks every slot and then runs the divider. A scanning tick visits each slot; a
// slot that stays armed also passes through S_TMIN, a free or released one does not.
// Synchronous active-high reset clears the table and the due bound; no clearing pass.
// The command queue (2 items) keeps accepting until full while a full result queue stalls the engine.
module periodic_timer_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ptt_pkg::req_type  req_data,
   output logic              empty,
   input  logic              pop,
   output ptt_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [1:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   logic [19:0]      tick_ff, tick_in;
   logic             cmd_valid, cmd_take, eng_push, eng_full;
   ptt_pkg::cmd_type cmd_data;
   ptt_pkg::rsp_type eng_rsp;

   assign pready  = 1'b1;
   assign prdata  = {12'd0, tick_ff};
   assign tick_in = (psel && penable && pwrite && paddr == ptt_pkg::ADDR_TICK) ? pwdata[19:0]
                                                                              : tick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= ptt_pkg::TICK_RESET;
      end else begin
         tick_ff <= tick_in;
      end
   end

   ptt_cmd_queue u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   ptt_engine u_eng (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_data       (cmd_data),
      .cmd_take       (cmd_take),
      .tick_period_us (tick_ff),
      .rsp_full       (eng_full),
      .rsp_push       (eng_push),
      .rsp_out        (eng_rsp)
   );

   ptt_rsp_queue u_rspq (
      .clock    (clock),
      .reset    (reset),
      .in_push  (eng_push),
      .in_full  (eng_full),
      .in_data  (eng_rsp),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the periodic timer table: table-driven and random commands.
`timescale 1ns / 1ps
module tb_top;
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             full;
   ptt_pkg::req_type req_data = '0;
   logic             empty;
   logic             pop = 1'b0;
   ptt_pkg::rsp_type rsp_data;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [1:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   periodic_timer_table uut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   localparam int QUIET_LIMIT = 5000;

   // Shadow copy of the timer table.
   bit [19:0]  tick_len_us;
   bit         slot_used [ptt_pkg::SLOTS];
   bit [31:0]  slot_tid [ptt_pkg::SLOTS];
   bit [39:0]  slot_per [ptt_pkg::SLOTS];
   bit [63:0]  slot_due [ptt_pkg::SLOTS];
   bit [31:0]  slot_left [ptt_pkg::SLOTS];
   bit [31:0]  slot_par [ptt_pkg::SLOTS];
   bit [63:0]  next_due;

   ptt_pkg::rsp_type expected_rsp [$];
   int         mismatches = 0;
   int         quiet_cycles = 0;
   bit         no_idle = 1'b0;
   bit         hold_request = 1'b0;
   bit [63:0]  now_base = 64'd0;

   typedef struct {
      ptt_pkg::req_type cmd;
      bit               known;
      logic [2:0]       kind;
   } step_row;

   step_row steps [$];

   task automatic add_rsp(logic [2:0] kind, logic [31:0] id, logic [31:0] par);
      ptt_pkg::rsp_type o;
      o.result_kind = kind;
      o.fired_id = id;
      o.fired_param = par;
      o.last = 1'b0;
      expected_rsp = {expected_rsp, o};
   endtask

   task automatic add_step(ptt_pkg::req_type c, bit k, logic [2:0] kd);
      step_row row;
      row.cmd = c;
      row.known = k;
      row.kind = kd;
      steps = {steps, row};
   endtask

   function automatic int lookup_slot(bit [31:0] id);
      int hit;
      hit = -1;
      for (int j = ptt_pkg::SLOTS - 1; j >= 0; j--)
         if (slot_used[j] && slot_tid[j] == id) hit = j;
      return hit;
   endfunction

   task automatic predict_timer(ptt_pkg::req_type r);
      int s;
      bit [63:0] tms, ms, nxt;
      bit any;
      case (r.func)
         ptt_pkg::FUNC_SET: begin
            if (r.repeat_count == 32'd0) begin
               add_rsp(ptt_pkg::KIND_REP_ZERO, r.timer_id, 32'd0);
            end else begin
               s = lookup_slot(r.timer_id);
               if (s < 0)
                  for (int j = ptt_pkg::SLOTS - 1; j >= 0; j--) if (!slot_used[j]) s = j;
               if (s < 0) begin
                  add_rsp(ptt_pkg::KIND_FULL, r.timer_id, 32'd0);
               end else begin
                  tms = 64'(tick_len_us) / 64'd1000;
                  if (tms == 64'd0) tms = 64'd1;
                  ms = (64'(r.period_s) * 64'd1000 + tms - 64'd1) / tms * tms;
                  slot_used[s] = 1'b1;
                  slot_tid[s] = r.timer_id;
                  slot_per[s] = 40'(ms * 64'd1000);
                  slot_due[s] = r.now_us + 64'(slot_per[s]);
                  slot_left[s] = r.repeat_count;
                  slot_par[s] = r.user_param;
                  if (slot_due[s] < next_due) next_due = slot_due[s];
                  add_rsp(ptt_pkg::KIND_SET_OK, r.timer_id, 32'd0);
               end
            end
         end
         ptt_pkg::FUNC_KILL: begin
            s = lookup_slot(r.timer_id);
            if (s < 0) begin
               add_rsp(ptt_pkg::KIND_NOTFOUND, r.timer_id, 32'd0);
            end else begin
               slot_used[s] = 1'b0;
               any = 1'b0;
               for (int j = 0; j < ptt_pkg::SLOTS; j++) any |= slot_used[j];
               if (!any) next_due = ptt_pkg::NONE_DUE;
               add_rsp(ptt_pkg::KIND_KILLED, r.timer_id, 32'd0);
            end
         end
         ptt_pkg::FUNC_KALL: begin
            for (int j = 0; j < ptt_pkg::SLOTS; j++) slot_used[j] = 1'b0;
            next_due = ptt_pkg::NONE_DUE;
            add_rsp(ptt_pkg::KIND_ALL_KILL, 32'd0, 32'd0);
         end
         default: begin
            if (next_due != ptt_pkg::NONE_DUE && next_due <= r.now_us) begin
               nxt = ptt_pkg::NONE_DUE;
               for (int j = 0; j < ptt_pkg::SLOTS; j++) begin
                  if (slot_used[j]) begin
                     if (slot_due[j] <= r.now_us) begin
                        add_rsp(ptt_pkg::KIND_FIRE, slot_tid[j], slot_par[j]);
                        if (slot_left[j] != ptt_pkg::FOREVER && slot_left[j] <= 32'd1) begin
                           slot_used[j] = 1'b0;
                        end else begin
                           if (slot_left[j] != ptt_pkg::FOREVER) slot_left[j]--;
                           slot_due[j] += 64'(slot_per[j]);
                        end
                     end
                     if (slot_used[j] && slot_due[j] < nxt) nxt = slot_due[j];
                  end
               end
               next_due = nxt;
            end
            add_rsp(ptt_pkg::KIND_TICKDONE, 32'd0, 32'd0);
         end
      endcase
      expected_rsp[expected_rsp.size() - 1].last = 1'b1;
   endtask

   function automatic bit idle_now();
      return !no_idle && ($urandom_range(99) < 11);
   endfunction

   // Offers one item until it is accepted; returns the kind of its first predicted result.
   task automatic send_item(ptt_pkg::req_type r, output logic [2:0] lead_kind);
      bit taken;
      int first;
      taken = 1'b0;
      lead_kind = '0;
      while (!taken) begin
         @(negedge clock);
         req_data = r;
         push = !idle_now();
         @(posedge clock);
         if (push && !full) begin
            taken = 1'b1;
            first = expected_rsp.size();
            predict_timer(r);
            lead_kind = expected_rsp[first].result_kind;
         end
      end
      @(negedge clock);
      push = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_tick_len(bit [19:0] val);
      wait_drained();
      repeat (100) @(posedge clock);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = ptt_pkg::ADDR_TICK;
      pwdata = 32'(val);
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      tick_len_us = val;
      @(negedge clock);
      pwrite = 1'b0; penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata[19:0] !== val) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tick length readback: expected %0d, got %0d", val, prdata[19:0]);
      end
      @(negedge clock);
      psel = 1'b0; penable = 1'b0;
   endtask

   function automatic ptt_pkg::req_type random_cmd();
      ptt_pkg::req_type r;
      int pick;
      r.user_param = $urandom();
      r.timer_id = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(23));
      r.period_s = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(4));
      case ($urandom_range(9))
         0: r.repeat_count = 32'd0;
         1: r.repeat_count = ptt_pkg::FOREVER;
         2: r.repeat_count = $urandom();
         default: r.repeat_count = 32'($urandom_range(1, 4));
      endcase
      pick = $urandom_range(99);
      if (pick < 40) r.func = ptt_pkg::FUNC_SET;
      else if (pick < 55) r.func = ptt_pkg::FUNC_KILL;
      else if (pick < 58) r.func = ptt_pkg::FUNC_KALL;
      else r.func = ptt_pkg::FUNC_TICK;
      if (r.func == ptt_pkg::FUNC_TICK) now_base += 64'($urandom_range(3000000));
      r.now_us = ($urandom_range(29) == 0) ? {$urandom(), $urandom()} : now_base;
      return r;
   endfunction

   function automatic ptt_pkg::req_type mk(logic [1:0] f, logic [31:0] id, logic [15:0] p,
                                           logic [31:0] rc, logic [31:0] par,
                                           logic [63:0] t);
      ptt_pkg::req_type r;
      r.func = f; r.timer_id = id; r.period_s = p;
      r.repeat_count = rc; r.user_param = par; r.now_us = t;
      return r;
   endfunction

   initial begin
      logic [2:0] lead;
      bit [19:0] tick_choice [5];
      tick_choice[0] = 20'd1000;
      tick_choice[1] = 20'd1000000;
      tick_choice[2] = 20'($urandom_range(1000, 1000000));
      tick_choice[3] = 20'd999;
      tick_choice[4] = ptt_pkg::TICK_RESET;
      tick_len_us = ptt_pkg::TICK_RESET;
      next_due = ptt_pkg::NONE_DUE;
      for (int j = 0; j < ptt_pkg::SLOTS; j++) slot_used[j] = 1'b0;

      add_step(mk(ptt_pkg::FUNC_TICK, '0, '0, '0, '0, '0), 1'b1, ptt_pkg::KIND_TICKDONE);
      add_step(mk(ptt_pkg::FUNC_KILL, 32'd5, '0, '0, '0, '0), 1'b1, ptt_pkg::KIND_NOTFOUND);
      add_step(mk(ptt_pkg::FUNC_SET, 32'd7, 16'd3, '0, 32'd9, '0), 1'b1,
               ptt_pkg::KIND_REP_ZERO);
      add_step(mk(ptt_pkg::FUNC_SET, 32'd1, '0, 32'd3, 32'h55, '0), 1'b1,
               ptt_pkg::KIND_SET_OK);
      add_step(mk(ptt_pkg::FUNC_TICK, '0, '0, '0, '0, '0), 1'b0, '0);
      add_step(mk(ptt_pkg::FUNC_TICK, '0, '0, '0, '0, '0), 1'b0, '0);
      add_step(mk(ptt_pkg::FUNC_SET, 32'd1, 16'd2, 32'd1, 32'hAA, 64'd100), 1'b1,
               ptt_pkg::KIND_SET_OK);
      add_step(mk(ptt_pkg::FUNC_SET, '1, '1, ptt_pkg::FOREVER, '1, 64'hFFFF_FFFF_FFFF_0000),
               1'b1, ptt_pkg::KIND_SET_OK);
      add_step(mk(ptt_pkg::FUNC_TICK, '0, '0, '0, '0, '1), 1'b0, '0);
      add_step(mk(ptt_pkg::FUNC_KILL, 32'd1, '0, '0, '0, '0), 1'b0, '0);
      add_step(mk(ptt_pkg::FUNC_KILL, '1, '0, '0, '0, '0), 1'b1, ptt_pkg::KIND_KILLED);
      add_step(mk(ptt_pkg::FUNC_KALL, '0, '0, '0, '0, '0), 1'b1, ptt_pkg::KIND_ALL_KILL);
      // Fill every slot, then one more set must be refused.
      for (int j = 0; j <= ptt_pkg::SLOTS; j++)
         add_step(mk(ptt_pkg::FUNC_SET, 32'(100 + j), 16'(j), 32'd2, 32'(j), '0), 1'b1,
                  (j == ptt_pkg::SLOTS) ? ptt_pkg::KIND_FULL : ptt_pkg::KIND_SET_OK);
      add_step(mk(ptt_pkg::FUNC_TICK, '0, '0, '0, '0, 64'd20_000_000), 1'b0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (steps[n]) begin
         send_item(steps[n].cmd, lead);
         if (steps[n].known && lead !== steps[n].kind) begin
            mismatches++;
            if (mismatches <= 10)
               $display("step %0d: table kind %0d, predicted %0d", n, steps[n].kind, lead);
         end
      end

      for (int ph = 0; ph < 5; ph++) begin
         write_tick_len(tick_choice[ph]);
         no_idle = (ph == 1);
         for (int n = 0; n < 52; n++) begin
            if (ph == 2 && n == 5) hold_request = 1'b1;
            if (ph == 3 && n == 26) wait_drained();
            send_item(random_cmd(), lead);
         end
      end
      no_idle = 1'b0;
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Result side: random pop, plus one long hold-off so the command side backs up.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            pop = 1'b0;
         end else begin
            pop = !idle_now();
         end
      end
   end

   always @(posedge clock) begin
      ptt_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: kind %0d id %h", rsp_data.result_kind,
                        rsp_data.fired_id);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected kind %0d id %h par %h last %b, ",
                            "got kind %0d id %h par %h last %b"},
                           want.result_kind, want.fired_id, want.fired_param, want.last,
                           rsp_data.result_kind, rsp_data.fired_id, rsp_data.fired_param,
                           rsp_data.last);
            end
         end
      end
   end

   // Watchdog on cycles in which no item and no register write is accepted.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable && pwrite)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end
endmodule
